>>> design/fqs_pkg.sv
// Shared types and constants for the searchable FIFO queue.
package fqs_pkg;

  localparam int VAL_W     = 32;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;
  // Rotation distance is non-negative, so only its low 31 bits feed the divider
  localparam int DIV_STEPS = 31;
  localparam int DIV_CNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_COUNT  = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_ROTATE = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SCAN,
    S_DIV,
    S_ROT,
    S_ENDS,
    S_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic pop_upd;
    logic scan_step;
    logic div_step;
    logic rot_upd;
    logic ends_rd;
    logic out_ld;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             rot_skip;
    logic             scan_done;
    logic             div_last;
  } dp_sts_t;

endpackage

>>> design/fifo_queue_with_search_core.sv
// Top level of the searchable FIFO queue: controller plus datapath.
//
//   channel | direction | tdata (low bit up)                         | tuser
//   in_     | slave     | value[31:0], amount[31:0]                  | cmd[2:0]
//   out_    | master    | popped, front_value, back_value, length,   | status[1:0]
//           |           | match_count, position, found, zero pad     |
//
// One command word is worked at a time. Count and find walk the occupied
// slots in a one-slot-a-cycle memory walk; rotate runs the 31-step remainder
// unit, which is skipped on an empty queue or a negative distance. A stalled
// output adds the wait for out_tready.
// Reset empties the queue; the ring memory itself is not cleared.
module fifo_queue_with_search_core import fqs_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [2*VAL_W-1:0]   in_tdata,   // value, amount
  input  logic [CMD_W-1:0]     in_tuser,   // cmd
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // popped, front_value, back_value, length, match_count, position, found
  output logic [((3*VAL_W+3*$clog2(DEPTH+1)+1+7)/8)*8-1:0] out_tdata,
  output logic [STAT_W-1:0]    out_tuser   // status
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  fqs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (dp_sts),
    .cmd        (dp_cmd)
  );

  fqs_dp #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

>>> design/fqs_ctrl.sv
// Sequencer for the searchable FIFO queue: one command word at a time.
module fqs_ctrl import fqs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (sts.cmd)
          CMD_POP:              state_nxt = sts.empty ? S_ENDS : S_POP;
          CMD_COUNT, CMD_FIND:  state_nxt = S_SCAN;
          CMD_ROTATE:           state_nxt = sts.rot_skip ? S_ENDS : S_DIV;
          default:              state_nxt = S_ENDS;
        endcase
      end
      S_POP:  state_nxt = S_ENDS;
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_ENDS;
      end
      S_DIV: begin
        if (sts.div_last) state_nxt = S_ROT;
      end
      S_ROT:  state_nxt = S_ENDS;
      S_ENDS: state_nxt = S_OUT;
      S_OUT: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && in_tvalid;
    cmd.exec      = (state_r == S_EXEC);
    cmd.pop_upd   = (state_r == S_POP);
    cmd.scan_step = (state_r == S_SCAN);
    cmd.div_step  = (state_r == S_DIV);
    cmd.rot_upd   = (state_r == S_ROT);
    cmd.ends_rd   = (state_r == S_ENDS);
    cmd.out_ld    = (state_r == S_OUT) && slot_free;
  end

  // Output word valid: set on load, drop once taken
  always_comb begin
    priority if (cmd.out_ld) out_valid_nxt = 1'b1;
    else if (out_tready)     out_valid_nxt = 1'b0;
    else                     out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/fqs_dp.sv
// Datapath for the searchable FIFO queue: ring memory, pointers, scan and divider.
module fqs_dp import fqs_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd,
  output dp_sts_t                       sts,
  input  logic [2*VAL_W-1:0]            in_tdata,
  input  logic [CMD_W-1:0]              in_tuser,
  output logic [((3*VAL_W+3*$clog2(DEPTH+1)+1+7)/8)*8-1:0] out_tdata,
  output logic [STAT_W-1:0]             out_tuser
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH+1);
  localparam int SW    = CW + 1;
  localparam int OUT_W = ((3*VAL_W + 3*CW + 1 + 7) / 8) * 8;

  // Ring index arithmetic: base plus offset, folded once into the depth
  function automatic logic [AW-1:0] wrap_idx(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
    return sum[AW-1:0];
  endfunction

  logic [VAL_W-1:0] mem [DEPTH];

  logic [CMD_W-1:0]     cmd_r;
  logic [VAL_W-1:0]     value_r;
  logic [VAL_W-1:0]     amount_r;
  logic [AW-1:0]        head_r;
  logic [CW-1:0]        occ_r;
  status_t              status_r;
  logic [VAL_W-1:0]     popped_r;
  logic [VAL_W-1:0]     rd_a_r;
  logic [VAL_W-1:0]     rd_b_r;
  logic [CW-1:0]        issue_idx_r;
  logic                 pend_r;
  logic [AW-1:0]        pend_idx_r;
  logic [CW-1:0]        match_r;
  logic [CW-1:0]        pos_r;
  logic                 found_r;
  logic [DIV_STEPS-1:0] div_q_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [CW-1:0]        rem_r;
  logic [OUT_W-1:0]     out_tdata_r;
  status_t              out_tuser_r;

  logic          full;
  logic          empty;
  logic          push_ok;
  logic          issue;
  logic          hit;
  logic [CW-1:0] occ_m1;
  logic [AW-1:0] ra_addr;
  logic [AW-1:0] rb_addr;
  logic          ra_en;
  logic [SW-1:0] trial;
  logic [SW-1:0] occ_x;

  assign full    = (occ_r == CW'(DEPTH));
  assign empty   = (occ_r == '0);
  assign push_ok = cmd.exec && (cmd_r == CMD_PUSH) && !full;
  assign issue   = cmd.scan_step && (issue_idx_r < occ_r);
  assign hit     = cmd.scan_step && pend_r && (rd_a_r == value_r);
  assign occ_m1  = occ_r - CW'(1);
  assign trial   = {rem_r, div_q_r[DIV_STEPS-1]};
  assign occ_x   = SW'(occ_r);

  assign sts.cmd       = cmd_r;
  assign sts.empty     = empty;
  assign sts.rot_skip  = empty || amount_r[VAL_W-1];
  assign sts.scan_done = !pend_r && (issue_idx_r >= occ_r);
  assign sts.div_last  = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // Read addresses: front for pop and ends, walking slot for scans
  always_comb begin
    ra_addr = head_r;
    if (cmd.scan_step) ra_addr = wrap_idx(head_r, issue_idx_r);
    rb_addr = empty ? head_r : wrap_idx(head_r, occ_m1);
    ra_en   = (cmd.exec && (cmd_r == CMD_POP)) || issue || cmd.ends_rd;
  end

  // Ring memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (push_ok) mem[wrap_idx(head_r, occ_r)] <= value_r;
    if (ra_en) rd_a_r <= mem[ra_addr];
    if (cmd.ends_rd) rd_b_r <= mem[rb_addr];
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      occ_r  <= '0;
    end else begin
      if (push_ok) occ_r <= occ_r + CW'(1);
      if (cmd.exec && (cmd_r == CMD_CLEAR)) begin
        head_r <= '0;
        occ_r  <= '0;
      end
      if (cmd.pop_upd) begin
        head_r <= wrap_idx(head_r, CW'(1));
        occ_r  <= occ_m1;
      end
      if (cmd.rot_upd) head_r <= wrap_idx(head_r, rem_r);
    end
  end

  // Capture command word and per-command results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_tuser;
      value_r  <= in_tdata[VAL_W-1:0];
      amount_r <= in_tdata[2*VAL_W-1:VAL_W];
    end
    if (cmd.exec) begin
      popped_r    <= '0;
      match_r     <= '0;
      pos_r       <= '0;
      found_r     <= 1'b0;
      issue_idx_r <= '0;
      pend_r      <= 1'b0;
      div_q_r     <= amount_r[DIV_STEPS-1:0];
      div_cnt_r   <= '0;
      rem_r       <= '0;
      priority if ((cmd_r == CMD_PUSH) && full)      status_r <= ST_FULL;
      else if ((cmd_r == CMD_POP) && empty)          status_r <= ST_EMPTY;
      else                                           status_r <= ST_OK;
    end
    if (cmd.pop_upd) popped_r <= rd_a_r;
    // Scan: issue one slot a cycle, compare it the cycle after
    if (cmd.scan_step) begin
      pend_r     <= issue;
      pend_idx_r <= issue_idx_r[AW-1:0];
      if (issue) issue_idx_r <= issue_idx_r + CW'(1);
    end
    if (hit) begin
      match_r <= match_r + CW'(1);
      if (!found_r) begin
        found_r <= 1'b1;
        pos_r   <= CW'(pend_idx_r) + CW'(1);
      end
    end
    // Restoring remainder, one dividend bit a step
    if (cmd.div_step) begin
      rem_r     <= (trial >= occ_x) ? CW'(trial - occ_x) : CW'(trial);
      div_q_r   <= div_q_r << 1;
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_tuser_r <= status_r;
      out_tdata_r <= OUT_W'({
        (cmd_r == CMD_FIND)  ? found_r : 1'b0,
        (cmd_r == CMD_FIND)  ? pos_r   : CW'(0),
        (cmd_r == CMD_COUNT) ? match_r : CW'(0),
        occ_r,
        empty ? VAL_W'(0) : rd_b_r,
        empty ? VAL_W'(0) : rd_a_r,
        popped_r});
    end
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule

>>> design/fqs_checker.sv
// Port-level checks for the searchable FIFO queue, bound to the top level.
module fqs_checker import fqs_pkg::*; #(
  parameter int DEPTH = 64
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [((3*VAL_W+3*$clog2(DEPTH+1)+1+7)/8)*8-1:0] out_tdata,
  input logic [STAT_W-1:0]    out_tuser
);

  localparam int CW    = $clog2(DEPTH+1);
  localparam int FR_LO = VAL_W;
  localparam int BK_LO = 2*VAL_W;
  localparam int LN_LO = 3*VAL_W;

  logic [VAL_W-1:0] popped;
  logic [VAL_W-1:0] front_v;
  logic [VAL_W-1:0] back_v;
  logic [CW-1:0]    len;

  assign popped  = out_tdata[VAL_W-1:0];
  assign front_v = out_tdata[FR_LO+VAL_W-1:FR_LO];
  assign back_v  = out_tdata[BK_LO+VAL_W-1:BK_LO];
  assign len     = out_tdata[LN_LO+CW-1:LN_LO];

  // Refused pop leaves an empty queue and pops nothing
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY) |-> (len == '0) && (popped == '0))
    else $error("empty status with nonzero length or popped word");

  // Refused push only happens on a full queue
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |-> (len == CW'(DEPTH)))
    else $error("full status while queue not full");

  // Empty queue reports zero ends
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (len == '0) |-> (front_v == '0) && (back_v == '0))
    else $error("empty queue reports nonzero front or back");

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

endmodule

bind fifo_queue_with_search_core fqs_checker #(.DEPTH(DEPTH)) u_fqs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
